// ===== rtl/gnc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gnc_pkg;

    localparam int unsigned VAL_W   = 24;
    localparam int unsigned MAXN_W  = 27;
    localparam int unsigned SUM_W   = 54;
    localparam int unsigned ROOT_W  = 27;
    localparam int unsigned DVD_W   = 47;
    localparam int unsigned COEF_W  = 21;
    localparam int unsigned PROD_W  = 45;
    localparam int unsigned FRAC_W  = 20;
    localparam logic [COEF_W-1:0] ONE_Q20  = 21'd1048576;
    localparam logic [MAXN_W-1:0] MAXN_RST = 27'd1048576;

    // one classified item as it travels through the queue
    typedef struct packed {
        logic [VAL_W-1:0] grad;
        logic             last;
        logic             keep;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_DIV,
        ST_RD,
        ST_MUL,
        ST_OUT
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/gradient_norm_clipper_top.sv =====
`timescale 1ns / 1ps
// sequence: after the back end pops the last item of a set it runs the root (27 steps)
// and the divide (47 steps), then for each stored item a read, a multiply and an output,
// so a new result comes only after the read and multiply states that follow the one before
// throughput: while the back end is idle, non-last items drain at one per cycle through a
// two-entry queue; busy rises while it is full, the per-set root and divide set the pace
// reset: synchronous active-low; clears the sum, counts and queue, norm cap to 1.0
// the receiver cannot stall: each result shows for one cycle with o_strobe
`default_nettype none
module gradient_norm_clipper_top
    import gnc_pkg::*;
#(
    parameter int unsigned MAX_ELEMENTS = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [VAL_W-1:0]  i_grad_value,
    input  wire logic              i_last_in,
    input  wire logic              i_cfg_we,
    input  wire logic [MAXN_W-1:0] i_cfg_wdata,
    output logic                   o_strobe,
    output logic [VAL_W-1:0]       o_clipped_value,
    output logic                   o_was_clipped,
    output logic                   o_last_out
);

    // store address and element count widths
    localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

    logic [MAXN_W-1:0] r_norm_cap;
    logic              w_avail;
    logic              w_pop;
    t_item             w_item;

    // norm cap register; the host must write it only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm_cap <= MAXN_RST;
        end else if (i_cfg_we) begin
            r_norm_cap <= i_cfg_wdata;
        end
    end

    // front end: takes items, marks the ones that overflow the store
    gnc_front #(.MAX_ELEMENTS(MAX_ELEMENTS), .CW(CW)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_grad_value (i_grad_value),
        .i_last_in    (i_last_in),
        .o_busy       (busy),
        .i_pop        (w_pop),
        .o_avail      (w_avail),
        .o_item       (w_item)
    );

    // back end: stores, sums squares, root, divide, scales each stored item
    gnc_back #(.MAX_ELEMENTS(MAX_ELEMENTS), .AW(AW), .CW(CW)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_avail         (w_avail),
        .i_item          (w_item),
        .o_pop           (w_pop),
        .i_norm_cap      (r_norm_cap),
        .o_strobe        (o_strobe),
        .o_clipped_value (o_clipped_value),
        .o_was_clipped   (o_was_clipped),
        .o_last_out      (o_last_out)
    );

    // results are spaced by the read and multiply cycles
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("back-to-back result strobes");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result strobe right after reset");

    // the queue only pops what it holds
    a_pop_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_avail)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== rtl/gnc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gnc_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/gnc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gnc_front
    import gnc_pkg::*;
#(
    parameter int unsigned MAX_ELEMENTS = 64,
    parameter int unsigned CW           = 7
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [VAL_W-1:0] i_grad_value,
    input  wire logic             i_last_in,
    output logic                  o_busy,
    input  wire logic             i_pop,
    output logic                  o_avail,
    output t_item                 o_item
);

    t_item       r_q [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_lvl;
    logic [CW-1:0] r_fcnt;
    logic        w_push;
    logic        w_pop;
    logic        w_keep;

    assign o_busy  = (r_lvl == 2'd2);
    assign o_avail = (r_lvl != 2'd0);
    assign o_item  = r_q[r_rp];
    assign w_push  = i_start && !o_busy;
    assign w_pop   = i_pop && o_avail;
    // items past the store's depth are dropped but still end the set
    assign w_keep  = (r_fcnt < CW'(MAX_ELEMENTS));

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{grad: i_grad_value, last: i_last_in, keep: w_keep};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_lvl  <= 2'd0;
            r_fcnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
                if (i_last_in) begin
                    r_fcnt <= '0;
                end else if (w_keep) begin
                    r_fcnt <= r_fcnt + CW'(1);
                end
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_lvl <= r_lvl + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/gnc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gnc_back
    import gnc_pkg::*;
#(
    parameter int unsigned MAX_ELEMENTS = 64,
    parameter int unsigned AW           = 6,
    parameter int unsigned CW           = 7
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_avail,
    input  t_item                  i_item,
    output logic                   o_pop,
    input  wire logic [MAXN_W-1:0] i_norm_cap,
    output logic                   o_strobe,
    output logic [VAL_W-1:0]       o_clipped_value,
    output logic                   o_was_clipped,
    output logic                   o_last_out
);

    t_state              r_state;
    t_state              n_state;
    logic [SUM_W-1:0]    r_sum;
    logic [CW-1:0]       r_n;
    logic [CW-1:0]       r_k;
    logic [5:0]          r_step;
    logic [SUM_W-1:0]    r_rad;
    logic [ROOT_W+1:0]   r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [ROOT_W-1:0]   r_div;
    logic [DVD_W-1:0]    r_dvd;
    logic [ROOT_W-1:0]   r_drem;
    logic [DVD_W-1:0]    r_q;
    logic [PROD_W-1:0]   r_prod;
    logic                r_neg;

    logic [VAL_W-1:0]    w_mag;
    logic [2*VAL_W-1:0]  w_sq;
    logic [SUM_W-1:0]    w_sum;
    logic [ROOT_W+3:0]   w_srem;
    logic [ROOT_W+3:0]   w_stest;
    logic [ROOT_W:0]     w_dt;
    logic [COEF_W-1:0]   w_coef;
    logic                w_clip;
    logic                w_ram_we;
    logic [VAL_W-1:0]    w_rdata;
    logic [VAL_W-1:0]    w_rmag;
    logic [PROD_W-1:0]   w_prod;
    logic [PROD_W-1:0]   w_rnd;
    logic [VAL_W-1:0]    w_rmg;
    logic                w_end;

    assign w_mag   = i_item.grad[VAL_W-1] ? (~i_item.grad + VAL_W'(1)) : i_item.grad;
    assign w_sq    = w_mag * w_mag;
    assign w_sum   = r_sum + SUM_W'(w_sq);
    // square root: two radicand bits per step
    assign w_srem  = {r_rem, r_rad[SUM_W-1 -: 2]};
    assign w_stest = (ROOT_W+4)'({r_root, 2'b01});
    // restoring division: one quotient bit per step
    assign w_dt    = {r_drem, r_dvd[DVD_W-1]};
    assign w_clip  = (r_q < DVD_W'(ONE_Q20));
    assign w_coef  = w_clip ? r_q[COEF_W-1:0] : ONE_Q20;
    assign w_rmag  = w_rdata[VAL_W-1] ? (~w_rdata + VAL_W'(1)) : w_rdata;
    assign w_prod  = w_rmag * w_coef;
    assign w_rnd   = r_prod + (PROD_W'(1) << (FRAC_W - 1));
    assign w_rmg   = w_rnd[FRAC_W +: VAL_W];
    assign w_end   = ((r_k + CW'(1)) == r_n);

    gnc_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ELEMENTS), .AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_n[AW-1:0]),
        .i_wdata (i_item.grad),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_avail && i_item.last) n_state = ST_SQRT;
            ST_SQRT: if (r_step == 6'd0) n_state = ST_DIV;
            ST_DIV:  if (r_step == 6'd0) n_state = ST_RD;
            ST_RD:   n_state = ST_MUL;
            ST_MUL:  n_state = ST_OUT;
            ST_OUT:  n_state = w_end ? ST_IDLE : ST_RD;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop           = (r_state == ST_IDLE) && i_avail;
        w_ram_we        = o_pop && i_item.keep;
        o_strobe        = (r_state == ST_OUT);
        o_clipped_value = r_neg ? (~w_rmg + VAL_W'(1)) : w_rmg;
        o_was_clipped   = w_clip;
        o_last_out      = w_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sum   <= '0;
            r_n     <= '0;
            r_k     <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        if (i_item.keep) begin
                            r_n <= r_n + CW'(1);
                        end
                        if (i_item.last) begin
                            r_rad  <= i_item.keep ? w_sum : r_sum;
                            r_sum  <= '0;
                            r_rem  <= '0;
                            r_root <= '0;
                            r_step <= 6'(ROOT_W - 1);
                            r_k    <= '0;
                        end else if (i_item.keep) begin
                            r_sum <= w_sum;
                        end
                    end
                end
                ST_SQRT: begin
                    r_rad <= r_rad << 2;
                    if (w_srem >= w_stest) begin
                        r_rem  <= (ROOT_W+2)'(w_srem - w_stest);
                        r_root <= {r_root[ROOT_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= (ROOT_W+2)'(w_srem);
                        r_root <= {r_root[ROOT_W-2:0], 1'b0};
                    end
                    if (r_step == 6'd0) begin
                        r_step <= 6'(DVD_W - 1);
                        r_drem <= '0;
                        r_dvd  <= {i_norm_cap, FRAC_W'(0)};
                    end else begin
                        r_step <= r_step - 6'd1;
                    end
                end
                ST_DIV: begin
                    r_dvd <= r_dvd << 1;
                    if (w_dt >= (ROOT_W+1)'(r_div)) begin
                        r_drem <= ROOT_W'(w_dt - (ROOT_W+1)'(r_div));
                        r_q    <= {r_q[DVD_W-2:0], 1'b1};
                    end else begin
                        r_drem <= ROOT_W'(w_dt);
                        r_q    <= {r_q[DVD_W-2:0], 1'b0};
                    end
                    if (r_step != 6'd0) begin
                        r_step <= r_step - 6'd1;
                    end
                end
                ST_RD: begin
                end
                ST_MUL: begin
                    r_prod <= w_prod;
                    r_neg  <= w_rdata[VAL_W-1];
                end
                ST_OUT: begin
                    r_k <= r_k + CW'(1);
                    if (w_end) begin
                        r_n <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // divisor is norm plus one lsb, loaded as the root finishes
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SQRT && r_step == 6'd0) begin
            r_div <= ((w_srem >= w_stest) ? {r_root[ROOT_W-2:0], 1'b1}
                                          : {r_root[ROOT_W-2:0], 1'b0}) + ROOT_W'(1);
        end
    end

endmodule
`default_nettype wire

// ===== tb/gradient_norm_clipper_top_tb.sv =====
`timescale 1ns / 1ps
module gradient_norm_clipper_top_tb;
    import gnc_pkg::*;

    localparam int unsigned STORE_DEPTH = 64;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned DRAIN_WAIT  = 200;
    localparam int unsigned REPORT_MAX  = 10;
    localparam logic [MAXN_W-1:0] MAXN_TOP = 27'd134217727;

    // one gradient element waiting to be sent, with its lead-in gap
    typedef struct {
        logic [VAL_W-1:0] grad;
        logic             last;
        int unsigned      gap;
    } t_pending;

    // one scaled element the block should emit
    typedef struct {
        logic [VAL_W-1:0] value;
        logic             clipped;
        logic             last;
    } t_scaled;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [VAL_W-1:0]  i_grad_value;
    logic              i_last_in;
    logic              i_cfg_we;
    logic [MAXN_W-1:0] i_cfg_wdata;
    logic              o_strobe;
    logic [VAL_W-1:0]  o_clipped_value;
    logic              o_was_clipped;
    logic              o_last_out;

    t_pending    pending_items[$];
    t_scaled     scaled_expected[$];
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned gap_left = 0;
    int unsigned items_made = 0;

    // predictor state
    logic signed [VAL_W-1:0] elem_copy[STORE_DEPTH];
    logic [63:0]             sq_total;
    int unsigned             elem_total;
    logic [MAXN_W-1:0]       norm_limit;

    gradient_norm_clipper_top #(.MAX_ELEMENTS(STORE_DEPTH)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_grad_value    (i_grad_value),
        .i_last_in       (i_last_in),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_strobe        (o_strobe),
        .o_clipped_value (o_clipped_value),
        .o_was_clipped   (o_was_clipped),
        .o_last_out      (o_last_out)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // bitwise floor square root
    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitpos;
        res = 0;
        bitpos = 64'd1 << 62;
        while (bitpos > v) bitpos = bitpos >> 2;
        while (bitpos != 0) begin
            if (v >= res + bitpos) begin
                v = v - (res + bitpos);
                res = (res >> 1) + bitpos;
            end else begin
                res = res >> 1;
            end
            bitpos = bitpos >> 2;
        end
        return res;
    endfunction

    // element times coefficient, round half away from zero
    function automatic logic [VAL_W-1:0] scale_elem(input logic signed [VAL_W-1:0] x,
                                                     input logic [63:0] coef);
        logic [63:0] mag;
        logic [63:0] r;
        mag = (x < 0) ? 64'(-64'(x)) : 64'(x);
        r = (mag * coef + 64'd524288) >> FRAC_W;
        if (x < 0) r = 64'd0 - r;
        return r[VAL_W-1:0];
    endfunction

    // take one accepted element; on last, queue the whole scaled set
    task automatic absorb_element(input logic [VAL_W-1:0] grad, input logic last);
        logic signed [VAL_W-1:0] g;
        logic [63:0] mag;
        logic [63:0] norm;
        logic [63:0] coef;
        t_scaled     s;
        g = grad;
        if (elem_total < STORE_DEPTH) begin
            elem_copy[elem_total] = g;
            mag = (g < 0) ? 64'(-64'(g)) : 64'(g);
            sq_total = sq_total + mag * mag;
            elem_total++;
        end
        if (last) begin
            norm = root_floor(sq_total);
            coef = (64'(norm_limit) << FRAC_W) / (norm + 1);
            if (coef > 64'(ONE_Q20)) coef = 64'(ONE_Q20);
            for (int k = 0; k < elem_total; k++) begin
                s.value = scale_elem(elem_copy[k], coef);
                s.clipped = (coef < 64'(ONE_Q20));
                s.last = (k + 1 == elem_total);
                scaled_expected.push_back(s);
            end
            sq_total = 0;
            elem_total = 0;
        end
    endtask

    // driver: accept on start && !busy, then load the next element after its gap
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && busy === 1'b0) && start) begin
            // held by busy, keep the item on the ports
        end else begin
            if (start) absorb_element(i_grad_value, i_last_in);
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (pending_items.size() > 0) begin
                if (pending_items[0].gap > 0) begin
                    gap_left <= pending_items[0].gap - 1;
                    pending_items[0].gap = 0;
                    start <= 1'b0;
                end else begin
                    i_grad_value <= pending_items[0].grad;
                    i_last_in <= pending_items[0].last;
                    start <= 1'b1;
                    void'(pending_items.pop_front());
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: every strobe must match the oldest expected scaled element
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) begin
            if (scaled_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: value %h clipped %b last %b",
                             o_clipped_value, o_was_clipped, o_last_out);
            end else begin
                if (o_clipped_value !== scaled_expected[0].value ||
                    o_was_clipped !== scaled_expected[0].clipped ||
                    o_last_out !== scaled_expected[0].last) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("mismatch: expected %h/%b/%b got %h/%b/%b",
                                 scaled_expected[0].value, scaled_expected[0].clipped,
                                 scaled_expected[0].last, o_clipped_value,
                                 o_was_clipped, o_last_out);
                end
                void'(scaled_expected.pop_front());
            end
        end
    end

    // watchdog against a hung block
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // mostly short gaps, a few long ones; quiet sets send back to back
    function automatic int unsigned pick_gap(input bit quiet);
        int unsigned r;
        if (quiet) return 0;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic queue_elem(input logic [VAL_W-1:0] g, input logic last, input bit quiet);
        t_pending p;
        p.grad = g;
        p.last = last;
        p.gap = pick_gap(quiet);
        pending_items.push_back(p);
        items_made++;
    endtask

    // random content: full-width, small or mid-size magnitudes
    function automatic logic [VAL_W-1:0] rand_grad();
        int unsigned r;
        logic signed [VAL_W-1:0] v;
        r = $urandom_range(0, 3);
        case (r)
            0: v = VAL_W'($urandom());
            1: v = VAL_W'($signed(VAL_W'($urandom_range(0, 4095))) - 2048);
            2: v = VAL_W'($signed(VAL_W'($urandom_range(0, 2097151))) - 1048576);
            default: v = VAL_W'($signed(VAL_W'($urandom_range(0, 262143))) - 131072);
        endcase
        return v;
    endfunction

    task automatic queue_set(input int unsigned len);
        bit quiet;
        quiet = ($urandom_range(0, 4) == 0);
        for (int k = 0; k < len; k++) queue_elem(rand_grad(), k == len - 1, quiet);
    endtask

    // wait until the block has emitted everything owed and settled
    task automatic wait_idle();
        while (pending_items.size() > 0 || start || gap_left > 0 || scaled_expected.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [MAXN_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        norm_limit = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_sets(input int unsigned count);
        int unsigned len;
        for (int s = 0; s < count; s++) begin
            case ($urandom_range(0, 9))
                0: len = $urandom_range(33, 64);
                1: len = $urandom_range(65, 68);
                default: len = $urandom_range(1, 12);
            endcase
            queue_set(len);
        end
    endtask

    initial begin
        start = 1'b0;
        i_grad_value = '0;
        i_last_in = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_rst_n = 1'b0;
        sq_total = 0;
        elem_total = 0;
        norm_limit = MAXN_RST;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: field extremes under the reset limit of 1.0
        queue_elem(24'h7FFFFF, 1'b1, 1'b1);
        queue_elem(24'h800000, 1'b1, 1'b1);
        queue_elem(24'h000000, 1'b1, 1'b1);
        queue_elem(24'h000001, 1'b0, 1'b1);
        queue_elem(24'hFFFFFF, 1'b1, 1'b1);
        queue_elem(24'h080000, 1'b0, 1'b0);
        queue_elem(24'hF80000, 1'b1, 1'b0);
        wait_idle();

        // zero limit: coefficient zero, everything clipped
        write_limit('0);
        queue_elem(24'h7FFFFF, 1'b0, 1'b1);
        queue_elem(24'h800000, 1'b1, 1'b1);
        queue_elem(24'h000000, 1'b1, 1'b1);
        wait_idle();

        // largest limit, and an overlong set with last past the store
        write_limit(MAXN_TOP);
        queue_elem(24'h555555, 1'b0, 1'b1);
        queue_elem(24'hAAAAAA, 1'b1, 1'b1);
        for (int k = 0; k < 66; k++) queue_elem(rand_grad(), k == 65, 1'b1);
        wait_idle();

        // random phases over several limits
        write_limit(MAXN_RST);
        random_sets(2);
        wait_idle();
        write_limit(27'($urandom_range(1, 4194304)));
        random_sets(2);
        wait_idle();
        write_limit(27'd1);
        random_sets(2);
        wait_idle();
        write_limit(MAXN_TOP);
        random_sets(2);
        wait_idle();
        while (items_made < 270) begin
            write_limit(27'($urandom()));
            random_sets(1);
            wait_idle();
        end

        if (mismatches == 0 && scaled_expected.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== gradient_norm_clipper_top.f =====
rtl/gnc_pkg.sv
rtl/gnc_ram.sv
rtl/gnc_front.sv
rtl/gnc_back.sv
rtl/gradient_norm_clipper_top.sv
tb/gradient_norm_clipper_top_tb.sv
